/* rtl/dpft_pkg.sv */
// shared types and constants of the demand paging translator
package dpft_pkg;

   localparam int NUM_FRAMES = 64;
   localparam int FRAME_W    = 6;
   localparam int PAGE_W     = 6;
   localparam int PID_W      = 4;
   localparam int OFFSET_W   = 8;
   localparam int PT_DEPTH   = 1024;
   localparam int PT_AW      = 10;
   localparam int OWN_W      = PID_W + PAGE_W;
   localparam int PTE_W      = 2 + FRAME_W;
   localparam int COUNT_W    = FRAME_W + 1;

   localparam logic [1:0] KIND_READ    = 2'd0;
   localparam logic [1:0] KIND_WRITE   = 2'd1;
   localparam logic [1:0] KIND_RELEASE = 2'd2;

   localparam logic [1:0] STATUS_DONE   = 2'd0;
   localparam logic [1:0] STATUS_FAULT  = 2'd1;
   localparam logic [1:0] STATUS_NO_PID = 2'd2;
   localparam logic [1:0] STATUS_RANGE  = 2'd3;

   localparam logic REG_PROCESS_COUNT = 1'b0;

   typedef struct packed {
      logic                valid;
      logic                dirty;
      logic [FRAME_W-1:0]  frame;
   } pte_type;

   typedef struct packed {
      logic [PID_W-1:0]  pid;
      logic [PAGE_W-1:0] page;
   } owner_type;

   // packed from the lowest bit up: status first
   typedef struct packed {
      logic [COUNT_W-1:0]  frames_freed;
      logic                writeback;
      logic [PAGE_W-1:0]   victim_page;
      logic [PID_W-1:0]    victim_pid;
      logic                evicted;
      logic [13:0]         physical_address;
      logic [1:0]          status;
   } result_type;

endpackage

/* rtl/dpft_ram.sv */
// generic simple dual-port ram with registered read
module dpft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/demand_paging_fifo_translator.sv */
// demand paging translator: page table walk, free frame stack and fifo replacement
// an access reads the page table; a hit answers from that read, a fault takes the
// top of the free frame stack, and with no free frame the oldest load queue entry
// is evicted after reads of its frame owner and page table rams; a failed access or
// an ignored word is answered from the idle state. a release walks every frame, then
// compacts the load queue. reset is synchronous; afterwards a clearing pass over the
// page table (also loading the free stack) runs before the first word is taken.
module demand_paging_fifo_translator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // pid[3:0], virtual_address[19:4], zero fill
   input  logic [1:0]  req_tuser,   // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // status, physical_address, evicted, victim_pid,
                                    // victim_page, writeback, frames_freed, zero fill
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [6:0]  csr_wdata
);

   localparam int FW    = dpft_pkg::FRAME_W;
   localparam int CW    = dpft_pkg::COUNT_W;
   localparam int RSP_W = $bits(dpft_pkg::result_type);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_PT, ST_OWN, ST_VIC, ST_FILL,
      ST_REL_RD, ST_REL_WR, ST_CMP_RD, ST_CMP_WR
   } state_type;

   state_type               state_ff;
   logic [4:0]              proc_count_ff;
   logic [6:0]              pages_ff;
   logic [dpft_pkg::PT_AW-1:0] clr_cnt_ff;
   logic [dpft_pkg::NUM_FRAMES-1:0] occ_ff;
   logic [CW-1:0]           free_count_ff;
   logic [FW-1:0]           head_ff;
   logic [FW-1:0]           tail_ff;
   logic [CW-1:0]           count_ff;
   logic [1:0]              kind_ff;
   logic [dpft_pkg::PID_W-1:0]  pid_ff;
   logic [dpft_pkg::PAGE_W-1:0] page_ff;
   logic [dpft_pkg::OFFSET_W-1:0] offset_ff;
   logic [FW-1:0]           frame_ff;
   dpft_pkg::owner_type     victim_ff;
   logic                    evicted_ff;
   logic [FW-1:0]           rel_cnt_ff;
   logic [CW-1:0]           freed_ff;
   logic [CW-1:0]           cmp_i_ff;
   logic [CW-1:0]           kept_ff;
   logic                    rsp_valid_ff;
   dpft_pkg::result_type    rsp_ff;

   logic [3:0]  req_pid;
   logic [15:0] req_va;
   logic        accept;

   logic                       pt_we;
   logic [dpft_pkg::PT_AW-1:0] pt_waddr, pt_raddr;
   dpft_pkg::pte_type          pt_wdata, pt_rdata;
   logic                       fs_we;
   logic [FW-1:0]              fs_waddr, fs_wdata, fs_raddr, fs_rdata;
   logic                       fq_we;
   logic [FW-1:0]              fq_waddr, fq_wdata, fq_raddr, fq_rdata;
   logic                       own_we;
   logic [FW-1:0]              own_waddr, own_raddr;
   dpft_pkg::owner_type        own_wdata, own_rdata;

   logic [CW-1:0] free_dec;
   logic          rel_match;

   assign req_pid    = req_tdata[3:0];
   assign req_va     = req_tdata[19:4];
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ff};
   assign free_dec   = free_count_ff - CW'(1);
   assign rel_match  = occ_ff[rel_cnt_ff] && (own_rdata.pid == pid_ff);

   dpft_ram #(.WIDTH(dpft_pkg::PTE_W), .DEPTH(dpft_pkg::PT_DEPTH)) u_page_table (
      .clock(clock), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
      .raddr(pt_raddr), .rdata(pt_rdata)
   );
   dpft_ram #(.WIDTH(FW), .DEPTH(dpft_pkg::NUM_FRAMES)) u_free_stack (
      .clock(clock), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
      .raddr(fs_raddr), .rdata(fs_rdata)
   );
   dpft_ram #(.WIDTH(FW), .DEPTH(dpft_pkg::NUM_FRAMES)) u_load_fifo (
      .clock(clock), .we(fq_we), .waddr(fq_waddr), .wdata(fq_wdata),
      .raddr(fq_raddr), .rdata(fq_rdata)
   );
   dpft_ram #(.WIDTH(dpft_pkg::OWN_W), .DEPTH(dpft_pkg::NUM_FRAMES)) u_frame_owner (
      .clock(clock), .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
      .raddr(own_raddr), .rdata(own_rdata)
   );

   // memory ports
   always_comb begin
      pt_we     = 1'b0;
      pt_waddr  = {pid_ff, page_ff};
      pt_wdata  = '0;
      pt_raddr  = {pid_ff, page_ff};
      fs_we     = 1'b0;
      fs_waddr  = free_count_ff[FW-1:0];
      fs_wdata  = rel_cnt_ff;
      fs_raddr  = free_dec[FW-1:0];
      fq_we     = 1'b0;
      fq_waddr  = tail_ff;
      fq_wdata  = frame_ff;
      fq_raddr  = head_ff;
      own_we    = 1'b0;
      own_waddr = frame_ff;
      own_wdata = {pid_ff, page_ff};
      own_raddr = frame_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            pt_we    = 1'b1;
            pt_waddr = clr_cnt_ff;
            fs_we    = (clr_cnt_ff < dpft_pkg::PT_AW'(dpft_pkg::NUM_FRAMES));
            fs_waddr = clr_cnt_ff[FW-1:0];
            fs_wdata = clr_cnt_ff[FW-1:0];
         end
         ST_IDLE: begin
            pt_raddr = {req_pid, req_va[13:8]};
         end
         ST_PT: begin
            own_raddr = fq_rdata;
            if (pt_rdata.valid && kind_ff == dpft_pkg::KIND_WRITE) begin
               pt_we    = 1'b1;
               pt_wdata = {1'b1, 1'b1, pt_rdata.frame};
            end
         end
         ST_OWN: begin
            pt_raddr = {own_rdata.pid, own_rdata.page};
         end
         ST_VIC: begin
            pt_we    = 1'b1;
            pt_waddr = {victim_ff.pid, victim_ff.page};
         end
         ST_FILL: begin
            pt_we    = 1'b1;
            pt_wdata = {1'b1, kind_ff == dpft_pkg::KIND_WRITE, frame_ff};
            own_we   = 1'b1;
            fq_we    = 1'b1;
         end
         ST_REL_RD: begin
            own_raddr = rel_cnt_ff;
         end
         ST_REL_WR: begin
            pt_we    = rel_match;
            pt_waddr = {own_rdata.pid, own_rdata.page};
            fs_we    = rel_match;
         end
         ST_CMP_RD: begin
            fq_raddr = head_ff + cmp_i_ff[FW-1:0];
         end
         ST_CMP_WR: begin
            fq_we    = occ_ff[fq_rdata];
            fq_waddr = head_ff + kept_ff[FW-1:0];
            fq_wdata = fq_rdata;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         proc_count_ff <= 5'd16;
         pages_ff      <= 7'd64;
         clr_cnt_ff    <= '0;
         occ_ff        <= '0;
         free_count_ff <= CW'(dpft_pkg::NUM_FRAMES);
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_addr == dpft_pkg::REG_PROCESS_COUNT) begin
               proc_count_ff <= csr_wdata[4:0];
            end else begin
               pages_ff <= csr_wdata;
            end
         end
         if (rsp_valid_ff && rsp_tready && !accept) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (&clr_cnt_ff) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  kind_ff    <= req_tuser;
                  pid_ff     <= req_pid;
                  page_ff    <= req_va[13:8];
                  offset_ff  <= req_va[7:0];
                  evicted_ff <= 1'b0;
                  victim_ff  <= '0;
                  rel_cnt_ff <= '0;
                  freed_ff   <= '0;
                  if (req_tuser == dpft_pkg::KIND_RELEASE) begin
                     rsp_ff       <= '0;
                     rsp_valid_ff <= 1'b0;
                     state_ff     <= ST_REL_RD;
                  end else if (req_tuser != dpft_pkg::KIND_READ &&
                               req_tuser != dpft_pkg::KIND_WRITE) begin
                     rsp_ff       <= '0;
                     rsp_valid_ff <= 1'b1;
                  end else if ({1'b0, req_pid} >= proc_count_ff) begin
                     rsp_ff       <= {{(RSP_W - 2){1'b0}}, dpft_pkg::STATUS_NO_PID};
                     rsp_valid_ff <= 1'b1;
                  end else if ({1'b0, req_va[15:8]} >= {2'b0, pages_ff} ||
                               req_va[15:14] != 2'b00) begin
                     rsp_ff       <= {{(RSP_W - 2){1'b0}}, dpft_pkg::STATUS_RANGE};
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     rsp_ff       <= '0;
                     rsp_valid_ff <= 1'b0;
                     state_ff     <= ST_PT;
                  end
               end
            end
            ST_PT: begin
               if (pt_rdata.valid) begin
                  rsp_ff       <= {{(RSP_W - 2 - FW - dpft_pkg::OFFSET_W){1'b0}},
                                   pt_rdata.frame, offset_ff, dpft_pkg::STATUS_DONE};
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end else if (free_count_ff != '0) begin
                  frame_ff      <= fs_rdata;
                  free_count_ff <= free_dec;
                  state_ff      <= ST_FILL;
               end else begin
                  // queue is full here: evict the oldest frame
                  frame_ff <= fq_rdata;
                  head_ff  <= head_ff + 1'b1;
                  count_ff <= count_ff - 1'b1;
                  state_ff <= ST_OWN;
               end
            end
            ST_OWN: begin
               victim_ff  <= own_rdata;
               evicted_ff <= 1'b1;
               state_ff   <= ST_VIC;
            end
            ST_VIC: begin
               rsp_ff.writeback <= pt_rdata.dirty;
               state_ff         <= ST_FILL;
            end
            ST_FILL: begin
               occ_ff[frame_ff] <= 1'b1;
               tail_ff          <= tail_ff + 1'b1;
               count_ff         <= count_ff + 1'b1;
               rsp_ff           <= {CW'(0), rsp_ff.writeback, victim_ff.page, victim_ff.pid,
                                    evicted_ff, frame_ff, offset_ff,
                                    dpft_pkg::STATUS_FAULT};
               rsp_valid_ff     <= 1'b1;
               state_ff         <= ST_IDLE;
            end
            ST_REL_RD: begin
               state_ff <= ST_REL_WR;
            end
            ST_REL_WR: begin
               if (rel_match) begin
                  occ_ff[rel_cnt_ff] <= 1'b0;
                  free_count_ff      <= free_count_ff + 1'b1;
                  freed_ff           <= freed_ff + 1'b1;
               end
               rel_cnt_ff <= rel_cnt_ff + 1'b1;
               if (&rel_cnt_ff) begin
                  cmp_i_ff <= '0;
                  kept_ff  <= '0;
                  state_ff <= ST_CMP_RD;
               end else begin
                  state_ff <= ST_REL_RD;
               end
            end
            ST_CMP_RD: begin
               // compact surviving frames in place, starting at the head
               if (cmp_i_ff == count_ff) begin
                  tail_ff             <= head_ff + kept_ff[FW-1:0];
                  count_ff            <= kept_ff;
                  rsp_ff.frames_freed <= freed_ff;
                  rsp_valid_ff        <= 1'b1;
                  state_ff            <= ST_IDLE;
               end else begin
                  state_ff <= ST_CMP_WR;
               end
            end
            ST_CMP_WR: begin
               if (occ_ff[fq_rdata]) begin
                  kept_ff <= kept_ff + 1'b1;
               end
               cmp_i_ff <= cmp_i_ff + 1'b1;
               state_ff <= ST_CMP_RD;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

/* test/tb.sv */
// self-checking bench for the demand paging translator: address translation, faults, fifo eviction, releases, limits
module tb;

   localparam logic [1:0] KIND_IGNORED          = 2'd3;
   localparam logic       REG_PAGES_PER_PROCESS = 1'b1;
   localparam int         CYCLE_LIMIT           = 2000000;
   localparam int         QUIET_TAIL            = 120;

   typedef enum logic [1:0] {OP_WORD, OP_CSR, OP_DRAIN} op_type;

   typedef struct {
      op_type      op;
      logic [1:0]  kind;
      logic [3:0]  pid;
      logic [15:0] va;
      logic        addr;
      logic [6:0]  wdata;
   } pending_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic        csr_addr = 1'b0;
   logic [6:0]  csr_wdata = '0;

   demand_paging_fifo_translator dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // translator state as the bench sees it
   logic                          pt_valid [dpft_pkg::PT_DEPTH];
   logic                          pt_dirty [dpft_pkg::PT_DEPTH];
   logic [dpft_pkg::FRAME_W-1:0]  pt_frame [dpft_pkg::PT_DEPTH];
   logic                          own_busy [dpft_pkg::NUM_FRAMES];
   logic [dpft_pkg::PID_W-1:0]    own_pid  [dpft_pkg::NUM_FRAMES];
   logic [dpft_pkg::PAGE_W-1:0]   own_page [dpft_pkg::NUM_FRAMES];
   logic [dpft_pkg::FRAME_W-1:0]  free_frames [$];
   logic [dpft_pkg::FRAME_W-1:0]  load_order [$];
   int                            proc_limit = 16;
   int                            page_limit = 64;

   pending_type           pending [$];
   dpft_pkg::result_type  expected_results [$];
   int           issued_n = 0, accepted_n = 0;
   int           cycles = 0, errors = 0;
   int           req_gap = 0, rsp_gap = 0, hold = 0;

   function automatic dpft_pkg::result_type translate(logic [1:0] kind, logic [3:0] pid,
                                                      logic [15:0] va);
      dpft_pkg::result_type r;
      int page, idx, fr, vidx, freed, np, ng;
      logic [dpft_pkg::FRAME_W-1:0] kept [$];
      r = '0;
      if (kind == dpft_pkg::KIND_RELEASE) begin
         freed = 0;
         for (int f = 0; f < dpft_pkg::NUM_FRAMES; f++) begin
            if (own_busy[f] && own_pid[f] == pid) begin
               idx = own_pid[f] * 64 + own_page[f];
               pt_valid[idx] = 1'b0;
               pt_dirty[idx] = 1'b0;
               pt_frame[idx] = '0;
               own_busy[f] = 1'b0;
               own_pid[f] = '0;
               own_page[f] = '0;
               free_frames.insert(free_frames.size(), f[dpft_pkg::FRAME_W-1:0]);
               freed++;
            end
         end
         // drop queue entries of freed frames wherever they sit
         foreach (load_order[i])
            if (own_busy[load_order[i]]) kept.insert(kept.size(), load_order[i]);
         load_order = kept;
         r.frames_freed = freed[dpft_pkg::COUNT_W-1:0];
         return r;
      end
      if (kind == KIND_IGNORED) return r;
      np = proc_limit < 16 ? proc_limit : 16;
      ng = page_limit < 64 ? page_limit : 64;
      if (pid >= np) begin
         r.status = dpft_pkg::STATUS_NO_PID;
         return r;
      end
      page = int'(va[15:8]);
      if (page >= ng) begin
         r.status = dpft_pkg::STATUS_RANGE;
         return r;
      end
      idx = pid * 64 + page;
      if (!pt_valid[idx]) begin
         r.status = dpft_pkg::STATUS_FAULT;
         if (free_frames.size() > 0) begin
            // top of the stack is the last entry
            fr = int'(free_frames[free_frames.size() - 1]);
            free_frames.delete(free_frames.size() - 1);
         end else begin
            if (load_order.size() == 0) begin
               r.status = dpft_pkg::STATUS_RANGE;
               return r;
            end
            fr = int'(load_order.pop_front());
            if (own_busy[fr]) begin
               vidx = own_pid[fr] * 64 + own_page[fr];
               r.evicted = 1'b1;
               r.victim_pid = own_pid[fr];
               r.victim_page = own_page[fr];
               if (pt_valid[vidx]) begin
                  r.writeback = pt_dirty[vidx];
                  pt_valid[vidx] = 1'b0;
                  pt_dirty[vidx] = 1'b0;
                  pt_frame[vidx] = '0;
               end
            end
         end
         own_busy[fr] = 1'b1;
         own_pid[fr] = pid;
         own_page[fr] = page[dpft_pkg::PAGE_W-1:0];
         pt_valid[idx] = 1'b1;
         pt_dirty[idx] = 1'b0;
         pt_frame[idx] = fr[dpft_pkg::FRAME_W-1:0];
         if (load_order.size() < dpft_pkg::NUM_FRAMES)
            load_order.insert(load_order.size(), fr[dpft_pkg::FRAME_W-1:0]);
      end
      if (kind == dpft_pkg::KIND_WRITE) pt_dirty[idx] = 1'b1;
      r.physical_address = {pt_frame[idx], va[7:0]};
      return r;
   endfunction

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // monitor: score results, then predict newly accepted words
   always @(posedge clock) begin
      dpft_pkg::result_type want, got;
      cycles <= cycles + 1;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = dpft_pkg::result_type'(rsp_tdata[$bits(dpft_pkg::result_type)-1:0]);
            if (expected_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected result word, expected none, actual %h", $time, got);
            end else begin
               want = expected_results.pop_front();
               check_field("status", want.status, got.status);
               check_field("physical_address", want.physical_address, got.physical_address);
               check_field("evicted", want.evicted, got.evicted);
               check_field("victim_pid", want.victim_pid, got.victim_pid);
               check_field("victim_page", want.victim_page, got.victim_page);
               check_field("writeback", want.writeback, got.writeback);
               check_field("frames_freed", want.frames_freed, got.frames_freed);
            end
         end
         if (req_tvalid && req_tready) begin
            expected_results.insert(expected_results.size(),
                                    translate(req_tuser, req_tdata[3:0], req_tdata[19:4]));
            accepted_n++;
         end
      end
   end

   // driver: request side, config writes and result-side stalls
   always @(negedge clock) begin
      pending_type p;
      logic v, we, quiet;
      if (!reset) begin
         quiet = pending.size() < QUIET_TAIL;
         if (quiet) rsp_tready <= 1'b1;
         else if (rsp_gap > 0) rsp_gap--;
         else if ($urandom_range(0, 15) == 0) begin
            rsp_gap = $urandom_range(1, 13) - 1;
            rsp_tready <= 1'b0;
         end else rsp_tready <= 1'b1;

         if (!(req_tvalid && accepted_n != issued_n)) begin
            v = 1'b0;
            we = 1'b0;
            if (hold > 0) hold--;
            else if (req_gap > 0) req_gap--;
            else if (pending.size() > 0) begin
               p = pending[0];
               case (p.op)
                  OP_DRAIN: begin
                     if (expected_results.size() == 0 && accepted_n == issued_n) begin
                        void'(pending.pop_front());
                        hold = 8;
                     end
                  end
                  OP_CSR: begin
                     void'(pending.pop_front());
                     we = 1'b1;
                     csr_addr <= p.addr;
                     csr_wdata <= p.wdata;
                     if (p.addr == dpft_pkg::REG_PROCESS_COUNT) proc_limit = int'(p.wdata[4:0]);
                     else page_limit = int'(p.wdata);
                  end
                  default: begin
                     if (!quiet && $urandom_range(0, 11) == 0)
                        req_gap = $urandom_range(1, 13) - 1;
                     else begin
                        void'(pending.pop_front());
                        v = 1'b1;
                        req_tdata <= {4'd0, p.va, p.pid};
                        req_tuser <= p.kind;
                        issued_n++;
                     end
                  end
               endcase
            end
            req_tvalid <= v;
            csr_we <= we;
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic add_word(logic [1:0] kind, logic [3:0] pid, logic [15:0] va);
      pending_type p;
      p = '{OP_WORD, kind, pid, va, 1'b0, 7'd0};
      pending.insert(pending.size(), p);
   endtask

   task automatic add_settings(int procs, int pages);
      pending_type p;
      p = '{OP_DRAIN, 2'd0, 4'd0, 16'd0, 1'b0, 7'd0};
      pending.insert(pending.size(), p);
      p = '{OP_CSR, 2'd0, 4'd0, 16'd0, dpft_pkg::REG_PROCESS_COUNT, procs[6:0]};
      pending.insert(pending.size(), p);
      p = '{OP_CSR, 2'd0, 4'd0, 16'd0, REG_PAGES_PER_PROCESS, pages[6:0]};
      pending.insert(pending.size(), p);
   endtask

   initial begin
      int procs [5] = '{16, 3, 0, 16, 1};
      int pages [5] = '{64, 20, 64, 1, 64};
      int np, ng, sel;
      logic [1:0]  k;
      logic [3:0]  pid;
      logic [15:0] va;

      for (int i = 0; i < dpft_pkg::PT_DEPTH; i++) begin
         pt_valid[i] = 0; pt_dirty[i] = 0; pt_frame[i] = 0;
      end
      for (int f = 0; f < dpft_pkg::NUM_FRAMES; f++) begin
         own_busy[f] = 0; own_pid[f] = 0; own_page[f] = 0;
         free_frames.insert(free_frames.size(), f[dpft_pkg::FRAME_W-1:0]);
      end

      // directed: corners under reset limits, then under three other limit settings
      add_word(dpft_pkg::KIND_READ, 4'd0, 16'h0000);
      add_word(dpft_pkg::KIND_WRITE, 4'd0, 16'h00ff);
      add_word(dpft_pkg::KIND_READ, 4'd0, 16'h0012);
      add_word(dpft_pkg::KIND_WRITE, 4'd15, 16'h3fff);
      add_word(dpft_pkg::KIND_WRITE, 4'd15, 16'hffff);
      add_word(dpft_pkg::KIND_READ, 4'd7, 16'h4000);
      add_word(KIND_IGNORED, 4'd5, 16'h1234);
      add_word(dpft_pkg::KIND_RELEASE, 4'd9, 16'hffff);
      add_word(dpft_pkg::KIND_RELEASE, 4'd15, 16'h0000);
      add_word(dpft_pkg::KIND_READ, 4'd15, 16'h3f00);
      add_word(dpft_pkg::KIND_READ, 4'd0, 16'h0001);
      add_settings(2, 4);
      add_word(dpft_pkg::KIND_READ, 4'd2, 16'h0000);
      add_word(dpft_pkg::KIND_READ, 4'd1, 16'h0300);
      add_word(dpft_pkg::KIND_WRITE, 4'd1, 16'h0400);
      add_word(dpft_pkg::KIND_RELEASE, 4'd12, 16'h0000);
      add_word(dpft_pkg::KIND_RELEASE, 4'd0, 16'h0000);
      add_settings(0, 0);
      add_word(dpft_pkg::KIND_READ, 4'd0, 16'h0000);
      add_settings(16, 0);
      add_word(dpft_pkg::KIND_WRITE, 4'd3, 16'h0000);

      // random phases through several limit settings
      for (int ph = 0; ph < 5; ph++) begin
         add_settings(procs[ph], pages[ph]);
         np = procs[ph] == 0 ? 1 : procs[ph];
         ng = pages[ph];
         for (int n = 0; n < 186; n++) begin
            sel = $urandom_range(0, 99);
            k = sel < 50 ? dpft_pkg::KIND_READ : sel < 92 ? dpft_pkg::KIND_WRITE :
                sel < 97 ? dpft_pkg::KIND_RELEASE : KIND_IGNORED;
            pid = $urandom_range(0, 9) == 0 ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(0, np - 1));
            va = 16'($urandom);
            if ($urandom_range(0, 9) != 0)
               va[15:8] = 8'($urandom_range(0, ng > 40 ? $urandom_range(0, 1) ? 15 : ng - 1
                                                       : ng - 1));
            add_word(k, pid, va);
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      wait (pending.size() == 0 && accepted_n == issued_n && expected_results.size() == 0);
      repeat (300) @(posedge clock);
      if (errors == 0 && expected_results.size() == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule

/* filelist.f */
rtl/dpft_pkg.sv
rtl/dpft_ram.sv
rtl/demand_paging_fifo_translator.sv
test/tb.sv
